[rtl/pft_pkg.sv]
`default_nettype none

package pft_pkg;

    // Field widths
    localparam int COORD_WIDTH = 16;
    localparam int INDEX_WIDTH = 20;
    localparam int FACE_WIDTH  = 20;
    localparam int NUM_AXES    = 3;
    localparam int AXIS_W      = $clog2(NUM_AXES);

    // Exact arithmetic widths
    localparam int DIF_W = COORD_WIDTH + 1;      // edge vector component
    localparam int PRD_W = 2 * DIF_W;           // cross product term
    localparam int NRM_W = PRD_W + 1;           // normal component
    localparam int LO_W  = (NRM_W + 1) / 2;     // low slice of a normal component
    localparam int HI_W  = NRM_W - LO_W;        // signed high slice
    localparam int PP_W  = 2 * LO_W + 1;        // partial product
    localparam int DOT_W = 2 * NRM_W + 2;       // dot product accumulator

    // Dot product sequence: partials, combine, accumulate overlap per axis
    localparam int DOT_PP_LAST = NUM_AXES - 1;
    localparam int DOT_LAST    = NUM_AXES + 1;
    localparam int CNT_W       = $clog2(DOT_LAST + 1);

    typedef logic        [INDEX_WIDTH-1:0] idx_t;
    typedef logic        [FACE_WIDTH-1:0]  face_t;
    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIF_W-1:0]       dif_t;
    typedef logic signed [PRD_W-1:0]       prd_t;
    typedef logic signed [NRM_W-1:0]       nrm_t;
    typedef logic signed [HI_W-1:0]        hi_t;
    typedef logic        [LO_W-1:0]        lo_t;
    typedef logic signed [PP_W-1:0]        pp_t;
    typedef logic signed [DOT_W-1:0]       dot_t;
    typedef logic        [AXIS_W-1:0]      axis_t;
    typedef logic        [CNT_W-1:0]       cnt_t;

    // Controller to datapath
    typedef struct packed {
        logic  load;
        logic  cross_en;
        logic  norm_en;
        logic  pp_en;
        axis_t axis;
        logic  prod_en;
        logic  acc_en;
        logic  finish;
    } pft_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic makes_tri;
        logic out_busy;
    } pft_stat_t;

endpackage

`default_nettype wire

[rtl/pft_if.sv]
`default_nettype none

interface pft_vertex_if;
    logic            valid;
    logic            ready;
    pft_pkg::idx_t   vertex_index;
    pft_pkg::coord_t pos_x;
    pft_pkg::coord_t pos_y;
    pft_pkg::coord_t pos_z;
    logic            face_end;

    modport source (
        output valid, vertex_index, pos_x, pos_y, pos_z, face_end,
        input  ready
    );
    modport sink (
        input  valid, vertex_index, pos_x, pos_y, pos_z, face_end,
        output ready
    );
endinterface

interface pft_triangle_if;
    logic           valid;
    logic           ready;
    pft_pkg::idx_t  corner_a;
    pft_pkg::idx_t  corner_b;
    pft_pkg::idx_t  corner_c;
    pft_pkg::face_t face_number;
    logic           nonconvex;
    logic           last_triangle;

    modport source (
        output valid, corner_a, corner_b, corner_c, face_number, nonconvex,
               last_triangle,
        input  ready
    );
    modport sink (
        input  valid, corner_a, corner_b, corner_c, face_number, nonconvex,
               last_triangle,
        output ready
    );
endinterface

`default_nettype wire

[rtl/pft_ctrl.sv]
`default_nettype none

module pft_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire pft_pkg::pft_stat_t stat,
    output pft_pkg::pft_cmd_t       cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CROSS = 3'd1;
    localparam logic [2:0] S_NORM  = 3'd2;
    localparam logic [2:0] S_DOT   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]    state_reg, state_next;
    pft_pkg::cnt_t cnt_reg, cnt_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (stat.makes_tri)
                    begin
                        state_next = S_CROSS;
                    end
                end
            end
            S_CROSS:
            begin
                cmd.cross_en = 1'b1;
                state_next   = S_NORM;
            end
            S_NORM:
            begin
                cmd.norm_en = 1'b1;
                cnt_next    = '0;
                state_next  = S_DOT;
            end
            S_DOT:
            begin
                // partials for axis n, combined in the next cycle, then accumulated
                cmd.axis    = cnt_reg[pft_pkg::AXIS_W-1:0];
                cmd.pp_en   = (cnt_reg <= pft_pkg::cnt_t'(pft_pkg::DOT_PP_LAST));
                cmd.prod_en = (cnt_reg >= pft_pkg::cnt_t'(1))
                           && (cnt_reg <= pft_pkg::cnt_t'(pft_pkg::NUM_AXES));
                cmd.acc_en  = (cnt_reg >= pft_pkg::cnt_t'(2));
                if (cnt_reg == pft_pkg::cnt_t'(pft_pkg::DOT_LAST))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + pft_pkg::cnt_t'(1);
                end
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[rtl/pft_datapath.sv]
`default_nettype none

module pft_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pft_pkg::pft_cmd_t cmd,
    output pft_pkg::pft_stat_t     stat,
    // vertex beat
    input  wire pft_pkg::idx_t     vertex_index,
    input  wire pft_pkg::coord_t   pos_x,
    input  wire pft_pkg::coord_t   pos_y,
    input  wire pft_pkg::coord_t   pos_z,
    input  wire logic              face_end,
    // triangle beat
    output logic                   out_valid,
    input  wire logic              out_ready,
    output pft_pkg::idx_t          corner_a,
    output pft_pkg::idx_t          corner_b,
    output pft_pkg::idx_t          corner_c,
    output pft_pkg::face_t         face_number,
    output logic                   nonconvex,
    output logic                   last_triangle
);

    localparam logic [1:0] CNT_EMPTY = 2'd0;
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_FULL  = 2'd2;

    localparam int N = pft_pkg::NUM_AXES;

    // face state
    pft_pkg::idx_t   first_idx_reg, prev_idx_reg;
    pft_pkg::coord_t first_crd_reg [N];
    pft_pkg::coord_t prev_crd_reg  [N];
    logic [1:0]      count_reg;
    pft_pkg::nrm_t   pnorm_reg [N];
    logic            bad_reg;
    pft_pkg::face_t  face_reg;

    // item in flight
    pft_pkg::idx_t   a_reg, b_reg, c_reg;
    logic            end_reg;
    pft_pkg::dif_t   e1_reg [N];
    pft_pkg::dif_t   e2_reg [N];
    pft_pkg::prd_t   pr_reg [2*N];
    pft_pkg::nrm_t   n_reg  [N];
    pft_pkg::pp_t    pp_hh_reg, pp_hl_reg, pp_lh_reg, pp_ll_reg;
    pft_pkg::dot_t   prod_reg, acc_reg;

    // result register
    logic            out_valid_reg;
    pft_pkg::idx_t   oa_reg, ob_reg, oc_reg;
    pft_pkg::face_t  of_reg;
    logic            onc_reg, olast_reg;

    pft_pkg::coord_t cur_w [N];
    pft_pkg::dif_t   e1_w  [N];
    pft_pkg::dif_t   e2_w  [N];
    pft_pkg::nrm_t   da_w, db_w;
    pft_pkg::pp_t    ah_w, al_w, bh_w, bl_w;
    pft_pkg::dot_t   comb_w;
    logic            bad_new;

    assign cur_w[0] = pos_x;
    assign cur_w[1] = pos_y;
    assign cur_w[2] = pos_z;

    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            e1_w[k] = pft_pkg::dif_t'(prev_crd_reg[k]) - pft_pkg::dif_t'(first_crd_reg[k]);
            e2_w[k] = pft_pkg::dif_t'(cur_w[k]) - pft_pkg::dif_t'(first_crd_reg[k]);
        end
    end

    // split each normal component into a signed high and an unsigned low slice
    assign da_w = pnorm_reg[cmd.axis];
    assign db_w = n_reg[cmd.axis];
    assign ah_w = pft_pkg::pp_t'(pft_pkg::hi_t'(da_w[pft_pkg::NRM_W-1:pft_pkg::LO_W]));
    assign bh_w = pft_pkg::pp_t'(pft_pkg::hi_t'(db_w[pft_pkg::NRM_W-1:pft_pkg::LO_W]));
    assign al_w = pft_pkg::pp_t'(pft_pkg::lo_t'(da_w[pft_pkg::LO_W-1:0]));
    assign bl_w = pft_pkg::pp_t'(pft_pkg::lo_t'(db_w[pft_pkg::LO_W-1:0]));

    assign comb_w = (pft_pkg::dot_t'(pp_hh_reg) <<< (2 * pft_pkg::LO_W))
                  + ((pft_pkg::dot_t'(pp_hl_reg) + pft_pkg::dot_t'(pp_lh_reg))
                     <<< pft_pkg::LO_W)
                  + pft_pkg::dot_t'(pp_ll_reg);

    assign bad_new = bad_reg | acc_reg[pft_pkg::DOT_W-1];

    assign stat.makes_tri = (count_reg == CNT_FULL);
    assign stat.out_busy  = out_valid_reg && !out_ready;

    // control and face state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_idx_reg <= '0;
            prev_idx_reg  <= '0;
            count_reg     <= CNT_EMPTY;
            bad_reg       <= 1'b0;
            face_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < N; k++)
            begin
                first_crd_reg[k] <= '0;
                prev_crd_reg[k]  <= '0;
                pnorm_reg[k]     <= '0;
            end
        end
        else
        begin
            if (cmd.load)
            begin
                prev_idx_reg <= vertex_index;
                for (int k = 0; k < N; k++)
                begin
                    prev_crd_reg[k] <= cur_w[k];
                end
                if (count_reg == CNT_EMPTY)
                begin
                    first_idx_reg <= vertex_index;
                    for (int k = 0; k < N; k++)
                    begin
                        first_crd_reg[k] <= cur_w[k];
                    end
                end
                if (face_end)
                begin
                    count_reg <= CNT_EMPTY;
                end
                else if (count_reg == CNT_EMPTY)
                begin
                    count_reg <= CNT_ONE;
                end
                else
                begin
                    count_reg <= CNT_FULL;
                end
                // short face: no triangle, normal and flag are still clear
                if (face_end && count_reg != CNT_FULL)
                begin
                    face_reg <= face_reg + pft_pkg::face_t'(1);
                end
            end

            if (cmd.finish)
            begin
                if (end_reg)
                begin
                    bad_reg  <= 1'b0;
                    face_reg <= face_reg + pft_pkg::face_t'(1);
                    for (int k = 0; k < N; k++)
                    begin
                        pnorm_reg[k] <= '0;
                    end
                end
                else
                begin
                    bad_reg <= bad_new;
                    for (int k = 0; k < N; k++)
                    begin
                        pnorm_reg[k] <= n_reg[k];
                    end
                end
            end

            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg   <= first_idx_reg;
            b_reg   <= prev_idx_reg;
            c_reg   <= vertex_index;
            end_reg <= face_end;
            for (int k = 0; k < N; k++)
            begin
                e1_reg[k] <= e1_w[k];
                e2_reg[k] <= e2_w[k];
            end
        end
        if (cmd.cross_en)
        begin
            pr_reg[0] <= pft_pkg::prd_t'(e1_reg[1]) * pft_pkg::prd_t'(e2_reg[2]);
            pr_reg[1] <= pft_pkg::prd_t'(e1_reg[2]) * pft_pkg::prd_t'(e2_reg[1]);
            pr_reg[2] <= pft_pkg::prd_t'(e1_reg[2]) * pft_pkg::prd_t'(e2_reg[0]);
            pr_reg[3] <= pft_pkg::prd_t'(e1_reg[0]) * pft_pkg::prd_t'(e2_reg[2]);
            pr_reg[4] <= pft_pkg::prd_t'(e1_reg[0]) * pft_pkg::prd_t'(e2_reg[1]);
            pr_reg[5] <= pft_pkg::prd_t'(e1_reg[1]) * pft_pkg::prd_t'(e2_reg[0]);
        end
        if (cmd.norm_en)
        begin
            for (int k = 0; k < N; k++)
            begin
                n_reg[k] <= pft_pkg::nrm_t'(pr_reg[2*k]) - pft_pkg::nrm_t'(pr_reg[2*k+1]);
            end
            acc_reg <= '0;
        end
        if (cmd.pp_en)
        begin
            pp_hh_reg <= ah_w * bh_w;
            pp_hl_reg <= ah_w * bl_w;
            pp_lh_reg <= al_w * bh_w;
            pp_ll_reg <= al_w * bl_w;
        end
        if (cmd.prod_en)
        begin
            prod_reg <= comb_w;
        end
        if (cmd.acc_en)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
        if (cmd.finish)
        begin
            oa_reg    <= a_reg;
            ob_reg    <= b_reg;
            oc_reg    <= c_reg;
            of_reg    <= face_reg;
            onc_reg   <= bad_new;
            olast_reg <= end_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign corner_a      = oa_reg;
    assign corner_b      = ob_reg;
    assign corner_c      = oc_reg;
    assign face_number   = of_reg;
    assign nonconvex     = onc_reg;
    assign last_triangle = olast_reg;

endmodule

`default_nettype wire

[rtl/polygon_fan_triangulator_core.sv]
// Polygon fan triangulator.
// vertices  (sink): one beat per polygon vertex, index, signed x/y/z and face_end
//                   on the last vertex of a face.
// triangles (source): one beat per fan triangle (first, previous, current corner),
//                   with the face count, the sticky non-convex flag and last mark.
// Faces of one or two vertices give no triangle but still advance face_number.
// A vertex that gives no triangle is taken at once and the next beat can
// follow straight after. A vertex that closes a triangle is taken with its
// edge vectors, then vertices.ready stays low through cross product, normal,
// a dot product with the previous normal through four sliced multipliers
// shared by the axes, and the write of the output register.
// The result sits in an output register, so vertices keep flowing while a beat
// waits; only the next triangle waits for triangles.ready before it is written.
// Reset (rst_n low, async) clears the face state, counter, flag and output valid.

`default_nettype none

module polygon_fan_triangulator_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    pft_vertex_if.sink      vertices,
    pft_triangle_if.source  triangles
);

    pft_pkg::pft_cmd_t  cmd;
    pft_pkg::pft_stat_t stat;

    // sequencer: owns vertices.ready and the dot-product step count
    pft_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (vertices.valid),
        .in_ready (vertices.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // face state, arithmetic and the output register
    pft_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .vertex_index  (vertices.vertex_index),
        .pos_x         (vertices.pos_x),
        .pos_y         (vertices.pos_y),
        .pos_z         (vertices.pos_z),
        .face_end      (vertices.face_end),
        .out_valid     (triangles.valid),
        .out_ready     (triangles.ready),
        .corner_a      (triangles.corner_a),
        .corner_b      (triangles.corner_b),
        .corner_c      (triangles.corner_c),
        .face_number   (triangles.face_number),
        .nonconvex     (triangles.nonconvex),
        .last_triangle (triangles.last_triangle)
    );

endmodule

`default_nettype wire

[rtl/pft_checker.sv]
`default_nettype none

module pft_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           in_valid,
    input wire logic           in_ready,
    input wire logic           out_valid,
    input wire logic           out_ready,
    input wire pft_pkg::idx_t  corner_a,
    input wire pft_pkg::idx_t  corner_c,
    input wire pft_pkg::face_t face_number,
    input wire logic           nonconvex
);

    // a stalled triangle beat stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("triangle beat dropped while stalled");

    // a stalled triangle beat keeps corner_a, corner_c, face_number and nonconvex
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(corner_a) && $stable(corner_c)
                                    && $stable(face_number) && $stable(nonconvex))
        else $error("triangle payload changed while stalled");

    // a new triangle only appears after the block was busy computing it
    a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("triangle beat without a compute phase");

    // the block goes busy only right after taking a vertex, and stays busy
    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid) ##1 !in_ready)
        else $error("ready dropped without a vertex or for too short");

endmodule

bind polygon_fan_triangulator_core pft_checker u_pft_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (vertices.valid),
    .in_ready    (vertices.ready),
    .out_valid   (triangles.valid),
    .out_ready   (triangles.ready),
    .corner_a    (triangles.corner_a),
    .corner_c    (triangles.corner_c),
    .face_number (triangles.face_number),
    .nonconvex   (triangles.nonconvex)
);

`default_nettype wire

[test/pft_fan_checker.sv]
module pft_fan_checker (
    input  logic    clk,
    input  logic    rst_n,
    pft_vertex_if   vertices,
    pft_triangle_if triangles,
    output int      mismatches,
    output int      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        pft_pkg::idx_t  corner_a;
        pft_pkg::idx_t  corner_b;
        pft_pkg::idx_t  corner_c;
        pft_pkg::face_t face_number;
        logic           nonconvex;
        logic           last_triangle;
    } tri_beat_t;

    // fan state, mirrors what the block keeps per face
    pft_pkg::idx_t  first_idx;
    pft_pkg::idx_t  prev_idx;
    longint         first_pos [3];
    longint         prev_pos [3];
    longint         prev_nrm [3];
    int             verts_seen;
    logic           face_bent;
    pft_pkg::face_t faces_done;
    tri_beat_t      expected_tris [$];

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // one accepted vertex; queues the fan triangle it closes, if any
    task automatic fan_vertex(input pft_pkg::idx_t idx, input pft_pkg::coord_t px,
                              input pft_pkg::coord_t py, input pft_pkg::coord_t pz,
                              input logic fin);
        longint             cur [3];
        longint             e1 [3];
        longint             e2 [3];
        longint             nrm [3];
        logic signed [79:0] dot_sum;
        logic signed [79:0] wa;
        logic signed [79:0] wb;
        tri_beat_t          beat;
        cur[0] = px;
        cur[1] = py;
        cur[2] = pz;
        if (verts_seen == 0)
        begin
            first_idx  = idx;
            first_pos  = cur;
            verts_seen = 1;
        end
        else if (verts_seen == 1)
        begin
            verts_seen = 2;
        end
        else
        begin
            for (int k = 0; k < 3; k++)
            begin
                e1[k] = prev_pos[k] - first_pos[k];
                e2[k] = cur[k] - first_pos[k];
            end
            nrm[0] = e1[1] * e2[2] - e1[2] * e2[1];
            nrm[1] = e1[2] * e2[0] - e1[0] * e2[2];
            nrm[2] = e1[0] * e2[1] - e1[1] * e2[0];
            // exact dot, only the sign matters; zero normal never flags
            dot_sum = '0;
            for (int k = 0; k < 3; k++)
            begin
                wa      = prev_nrm[k];
                wb      = nrm[k];
                dot_sum = dot_sum + wa * wb;
            end
            if (dot_sum < 0)
                face_bent = 1'b1;
            prev_nrm = nrm;
            beat.corner_a      = first_idx;
            beat.corner_b      = prev_idx;
            beat.corner_c      = idx;
            beat.face_number   = faces_done;
            beat.nonconvex     = face_bent;
            beat.last_triangle = fin;
            expected_tris.insert(expected_tris.size(), beat);
        end
        prev_idx = idx;
        prev_pos = cur;
        if (fin)
        begin
            verts_seen = 0;
            prev_nrm   = '{0, 0, 0};
            face_bent  = 1'b0;
            faces_done = faces_done + 1'b1;
        end
    endtask

    task automatic check_triangle();
        tri_beat_t want;
        if (expected_tris.size() == 0)
        begin
            report_mismatch($sformatf("triangle %0d/%0d/%0d face %0d with none expected",
                triangles.corner_a, triangles.corner_b, triangles.corner_c,
                triangles.face_number));
            return;
        end
        want = expected_tris.pop_front();
        if (triangles.corner_a      !== want.corner_a    ||
            triangles.corner_b      !== want.corner_b    ||
            triangles.corner_c      !== want.corner_c    ||
            triangles.face_number   !== want.face_number ||
            triangles.nonconvex     !== want.nonconvex   ||
            triangles.last_triangle !== want.last_triangle)
            report_mismatch({
                $sformatf("got a=%0d b=%0d c=%0d face=%0d nc=%b last=%b,",
                    triangles.corner_a, triangles.corner_b, triangles.corner_c,
                    triangles.face_number, triangles.nonconvex,
                    triangles.last_triangle),
                $sformatf(" want a=%0d b=%0d c=%0d face=%0d nc=%b last=%b",
                    want.corner_a, want.corner_b, want.corner_c,
                    want.face_number, want.nonconvex, want.last_triangle)});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_idx  = '0;
            prev_idx   = '0;
            first_pos  = '{0, 0, 0};
            prev_pos   = '{0, 0, 0};
            prev_nrm   = '{0, 0, 0};
            verts_seen = 0;
            face_bent  = 1'b0;
            faces_done = '0;
            expected_tris.delete();
            mismatches = 0;
            pending   <= 0;
        end
        else
        begin
            if (vertices.valid && vertices.ready)
                fan_vertex(vertices.vertex_index, vertices.pos_x, vertices.pos_y,
                           vertices.pos_z, vertices.face_end);
            if (triangles.valid && triangles.ready)
                check_triangle();
            pending <= expected_tris.size();
        end
    end

endmodule

[test/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Stimulus and verdict only; the checker beside the core predicts every
    // triangle beat and compares. Directed opener, then random faces of several
    // shapes with random gaps on both sides, two long output hold-offs, and a
    // closing stretch at full rate.

    localparam int RANDOM_ITEMS   = 1580;
    localparam int CALM_TAIL      = 200;   // final beats with no idling
    localparam int LONG_HOLD      = 150;   // output held off this many cycles
    localparam int HOLD_AT_A      = 300;
    localparam int HOLD_AT_B      = 900;
    localparam int DRAIN_CYCLES   = 40;    // extra wait for any stray triangle beat
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either side

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending;

    // shared knobs: idle_on enables random gaps on both sides,
    // long_hold_req asks the output side for one long hold-off
    logic idle_on;
    logic long_hold_req;

    // coordinate values at and around the ends of the range and around zero
    int   corner_vals [6] = '{-32768, -32767, -1, 0, 1, 32767};

    pft_vertex_if   vertices ();
    pft_triangle_if triangles ();

    polygon_fan_triangulator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .vertices  (vertices),
        .triangles (triangles)
    );

    pft_fan_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .vertices   (vertices),
        .triangles  (triangles),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Drive one vertex beat and hold it until the core takes it. Called right
    // after a rising edge; a random gap may come first when idling is on.
    task automatic send_vertex(input pft_pkg::idx_t idx, input int x, input int y,
                               input int z, input logic fin);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            vertices.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        vertices.valid        <= 1'b1;
        vertices.vertex_index <= idx;
        vertices.pos_x        <= pft_pkg::coord_t'(x);
        vertices.pos_y        <= pft_pkg::coord_t'(y);
        vertices.pos_z        <= pft_pkg::coord_t'(z);
        vertices.face_end     <= fin;
        @(posedge clk);
        while (!vertices.ready)
            @(posedge clk);
    endtask

    // Output side: random ready bursts, or one long hold-off on request so
    // the output register fills and the core stalls its vertex input.
    initial
    begin
        triangles.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                triangles.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 2) == 0)
            begin
                triangles.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                triangles.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    // Watchdog: ends the run if no beat moves on either channel for too long.
    initial
    begin
        int stalled_cycles;
        stalled_cycles = 0;
        while (stalled_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((vertices.valid && vertices.ready) || (triangles.valid && triangles.ready))
                stalled_cycles = 0;
            else
                stalled_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int            sent;
        int            face_len;
        int            shape;
        int            x;
        int            y;
        int            z;
        int            bx;
        int            by;
        int            bz;
        int            step;
        int            zstep;
        int            bend;
        pft_pkg::idx_t base_idx;
        pft_pkg::idx_t idx;
        logic          fin;

        rst_n         = 1'b0;
        idle_on       = 1'b1;
        long_hold_req = 1'b0;
        vertices.valid        <= 1'b0;
        vertices.vertex_index <= '0;
        vertices.pos_x        <= '0;
        vertices.pos_y        <= '0;
        vertices.pos_z        <= '0;
        vertices.face_end     <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed opener ----
        // short faces: one vertex, then two; no triangle, face count still moves
        send_vertex(20'd5, 1, 2, 3, 1'b1);
        send_vertex(20'd7, -4, 5, -6, 1'b0);
        send_vertex(20'd8, 9, -9, 9, 1'b1);
        // lone triangle at the index and coordinate extremes
        send_vertex(20'h00000, -32768, -32768, -32768, 1'b0);
        send_vertex(20'hFFFFF, 32767, -32768, 32767, 1'b0);
        send_vertex(20'hAAAAA, -32768, 32767, -32768, 1'b1);
        // convex square in the xy plane: two triangles, flag stays clear
        send_vertex(20'h55555, 0, 0, 0, 1'b0);
        send_vertex(20'd11, 100, 0, 0, 1'b0);
        send_vertex(20'd12, 100, 100, 0, 1'b0);
        send_vertex(20'd13, 0, 100, 0, 1'b1);
        // non-convex: second normal flips, flag sets and sticks to face end
        send_vertex(20'd20, 0, 0, 0, 1'b0);
        send_vertex(20'd21, 10, 0, 0, 1'b0);
        send_vertex(20'd22, 10, 10, 0, 1'b0);
        send_vertex(20'd23, 20, -5, 0, 1'b0);
        send_vertex(20'd24, 0, 20, 0, 1'b1);
        // degenerate: collinear triangle gives a zero normal, which flags
        // neither against the one before nor the one after
        send_vertex(20'd30, 0, 0, 0, 1'b0);
        send_vertex(20'd31, 5, 5, 5, 1'b0);
        send_vertex(20'd32, 10, 10, 10, 1'b0);
        send_vertex(20'd33, 0, -7, 3, 1'b0);
        send_vertex(20'd34, 1, 2, -9, 1'b1);
        // wide normals: products near full width in the dot product
        send_vertex(20'd40, -32768, -32768, 0, 1'b0);
        send_vertex(20'd41, 32767, -32768, 32767, 1'b0);
        send_vertex(20'd42, 32767, 32767, -32768, 1'b0);
        send_vertex(20'd43, -32768, 32767, 32767, 1'b0);
        send_vertex(20'd44, 32767, -32768, -32768, 1'b1);

        // ---- random faces ----
        // shapes: full-range noise, tiny coordinates (degenerate normals and
        // both turn directions), range extremes, planar convex fans on a
        // parabola, and broken faces with random end marks.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            face_len = ($urandom_range(0, 9) < 2) ? $urandom_range(1, 2)
                                                 : $urandom_range(3, 8);
            shape    = $urandom_range(0, 9);
            base_idx = pft_pkg::idx_t'($urandom);
            bx       = $urandom_range(0, 20000) - 10000;
            by       = $urandom_range(0, 20000) - 10000;
            bz       = $urandom_range(0, 20000) - 10000;
            step     = $urandom_range(1, 300);
            zstep    = $urandom_range(0, 600) - 300;
            bend     = $urandom_range(0, 1) ? 1 : -1;
            for (int k = 0; k < face_len; k++)
            begin
                idx = pft_pkg::idx_t'($urandom);
                fin = (k == face_len - 1);
                unique case (shape)
                    0, 1, 2, 9:
                    begin
                        x = $urandom_range(0, 65535) - 32768;
                        y = $urandom_range(0, 65535) - 32768;
                        z = $urandom_range(0, 65535) - 32768;
                        if (shape == 9)
                            fin = ($urandom_range(0, 3) == 0);
                    end
                    3, 4:
                    begin
                        x = $urandom_range(0, 16) - 8;
                        y = $urandom_range(0, 16) - 8;
                        z = $urandom_range(0, 16) - 8;
                    end
                    5:
                    begin
                        x = corner_vals[$urandom_range(0, 5)];
                        y = corner_vals[$urandom_range(0, 5)];
                        z = corner_vals[$urandom_range(0, 5)];
                    end
                    default:
                    begin
                        // points on a convex curve: every fan normal agrees
                        idx = base_idx + pft_pkg::idx_t'(k);
                        x   = bx + k * step;
                        y   = by + bend * k * k * step;
                        z   = bz + k * zstep;
                    end
                endcase
                if (sent == RANDOM_ITEMS - CALM_TAIL)
                    idle_on = 1'b0;
                if (sent == HOLD_AT_A || sent == HOLD_AT_B)
                    long_hold_req = 1'b1;
                send_vertex(idx, x, y, z, fin);
                sent++;
            end
        end
        vertices.valid <= 1'b0;

        // drain: wait for every expected triangle, then let any stray beat show
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
